// File: rtl/core/dpu_pkg.sv
// Types and constants shared by the depth pixel unprojection unit.
package dpu_pkg;

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [15:0] depth;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0]        point_z;
    logic [16:0]        ray_cosine;
  } out_item_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_MEAN = 3'd4;

  localparam logic [15:0] CENTER_RESET = 16'd8192;
  localparam logic [15:0] FOCAL_RESET  = 16'd8000;

  localparam int SQRT_W     = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [16:0] COS_ONE = 17'd65536;

endpackage

// File: rtl/core/dpu_div_pipe.sv
// Pipelined restoring divider producing one quotient bit per stage, with overflow flag.
module dpu_div_pipe #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 17,
  parameter int QUO_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  localparam int CW = DEN_W + QUO_W;

  logic [CW-1:0]    rem_r [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= CW'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= CW'(num) >= (CW'(den) << QUO_W);
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    localparam int B = QUO_W - 1 - i;
    logic [CW-1:0] trial;
    logic          take;
    assign trial = CW'(den_r[i]) << B;
    assign take  = rem_r[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= take ? rem_r[i] - trial : rem_r[i];
        den_r[i+1] <= den_r[i];
        quo_r[i+1] <= take ? (quo_r[i] | (QUO_W'(1) << B)) : quo_r[i];
        ovf_r[i+1] <= ovf_r[i];
      end
    end
  end

  assign quo = quo_r[QUO_W];
  assign ovf = ovf_r[QUO_W];

endmodule

// File: rtl/core/dpu_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module dpu_sqrt_pipe (
  input  logic                      clk,
  input  logic                      en,
  input  logic [dpu_pkg::SQRT_W-1:0] val,
  output logic [31:0]               root
);

  import dpu_pkg::*;

  logic [SQRT_W-1:0] rem_r  [0:SQRT_STEPS];
  logic [SQRT_W-1:0] root_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= val;
      root_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam int SH = SQRT_W - 2 - 2 * i;
    logic [SQRT_W-1:0] bitv;
    logic [SQRT_W-1:0] trial;
    logic              take;
    assign bitv  = SQRT_W'(1) << SH;
    assign trial = root_r[i] + bitv;
    assign take  = rem_r[i] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= take ? rem_r[i] - trial : rem_r[i];
        root_r[i+1] <= take ? (root_r[i] >> 1) + bitv : root_r[i] >> 1;
      end
    end
  end

  assign root = root_r[SQRT_STEPS][31:0];

endmodule

// File: rtl/core/depth_pixel_unprojection_unit.sv
// Top level of the depth pixel unprojection unit.
// Each depth pixel is back-projected through a pinhole camera into a point with
// 8 fraction bits and a Q1.16 view-ray cosine. The unit accepts one item per clock
// while the output is not stalled. The time through the unit is set by the 33-stage
// square root and the 18-stage cosine divider that follows it; the point dividers
// run beside the square root. A stalled output freezes the pipeline.
module depth_pixel_unprojection_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dpu_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dpu_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [dpu_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [dpu_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import dpu_pkg::*;

  localparam int XY_QW    = 32;
  localparam int XY_NW    = 42;
  localparam int XY_DW    = 17;
  localparam int C_QW     = 17;
  localparam int C_NW     = 47;
  localparam int C_DW     = 32;
  localparam int DIV_XY_L = XY_QW + 1;
  localparam int SQRT_L   = SQRT_STEPS + 1;
  localparam int DIV_C_L  = C_QW + 1;
  localparam int LAT_XY   = 3 + DIV_XY_L + 1;
  localparam int LAT      = 3 + SQRT_L + 1 + DIV_C_L + 1;
  localparam int XY_DLY   = LAT - LAT_XY;
  localparam int SGN_END  = 3 + DIV_XY_L;

  logic [15:0] center_x_r, center_y_r, focal_x_r, focal_y_r, focal_mean_r;
  logic [15:0] fx_nz, fy_nz, fm_nz;
  logic        adv;
  logic [LAT:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= CENTER_RESET;
      center_y_r   <= CENTER_RESET;
      focal_x_r    <= FOCAL_RESET;
      focal_y_r    <= FOCAL_RESET;
      focal_mean_r <= FOCAL_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CENTER_X:   center_x_r   <= cfg_wdata;
        CFG_CENTER_Y:   center_y_r   <= cfg_wdata;
        CFG_FOCAL_X:    focal_x_r    <= cfg_wdata;
        CFG_FOCAL_Y:    focal_y_r    <= cfg_wdata;
        CFG_FOCAL_MEAN: focal_mean_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fx_nz = (focal_x_r == '0) ? 16'd1 : focal_x_r;
  assign fy_nz = (focal_y_r == '0) ? 16'd1 : focal_y_r;
  assign fm_nz = (focal_mean_r == '0) ? 16'd1 : focal_mean_r;

  assign adv      = !vld_r[LAT] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-1:1], in_valid};
    end
  end

  // Stage 1: offsets from the principal point.
  logic signed [17:0] dx_r, dy_r;
  logic [15:0]        depth_r [1:LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r       <= $signed({4'b0, in_data.col, 4'b0}) - $signed({2'b0, center_x_r});
      dy_r       <= $signed({4'b0, in_data.row, 4'b0}) - $signed({2'b0, center_y_r});
      depth_r[1] <= in_data.depth;
      for (int i = 2; i <= LAT; i++) begin
        depth_r[i] <= depth_r[i-1];
      end
    end
  end

  // Stage 2: products and squares.
  logic [16:0] adx, ady;
  logic [31:0] px_r, py_r, sqx_r, sqy_r, sqf_r;
  logic        sgnx_r [2:SGN_END];
  logic        sgny_r [2:SGN_END];

  assign adx = dx_r[17] ? 17'(-dx_r) : dx_r[16:0];
  assign ady = dy_r[17] ? 17'(-dy_r) : dy_r[16:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r      <= 32'(adx * depth_r[1]);
      py_r      <= 32'(ady * depth_r[1]);
      sqx_r     <= 32'(adx * adx);
      sqy_r     <= 32'(ady * ady);
      sqf_r     <= 32'(fm_nz * fm_nz);
      sgnx_r[2] <= dx_r[17];
      sgny_r[2] <= dy_r[17];
      for (int i = 3; i <= SGN_END; i++) begin
        sgnx_r[i] <= sgnx_r[i-1];
        sgny_r[i] <= sgny_r[i-1];
      end
    end
  end

  // Stage 3: dividends with rounding term, and the squared ray length.
  logic [XY_NW-1:0] nx_r, ny_r;
  logic [33:0]      s_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r <= {1'b0, px_r, 9'b0} + XY_NW'(fx_nz);
      ny_r <= {1'b0, py_r, 9'b0} + XY_NW'(fy_nz);
      s_r  <= 34'(sqx_r) + 34'(sqy_r) + 34'(sqf_r);
    end
  end

  logic [XY_QW-1:0] qx, qy;
  logic             ovx, ovy;

  dpu_div_pipe #(.NUM_W(XY_NW), .DEN_W(XY_DW), .QUO_W(XY_QW)) u_div_x (
    .clk(clk), .en(adv), .num(nx_r), .den({fx_nz, 1'b0}), .quo(qx), .ovf(ovx)
  );

  dpu_div_pipe #(.NUM_W(XY_NW), .DEN_W(XY_DW), .QUO_W(XY_QW)) u_div_y (
    .clk(clk), .en(adv), .num(ny_r), .den({fy_nz, 1'b0}), .quo(qy), .ovf(ovy)
  );

  logic [31:0] sat_x, sat_y;
  logic [31:0] xo_r [0:XY_DLY];
  logic [31:0] yo_r [0:XY_DLY];

  always_comb begin
    if (sgnx_r[SGN_END]) begin
      sat_x = (ovx || qx > 32'h8000_0000) ? 32'h8000_0000 : 32'(-qx);
    end else begin
      sat_x = (ovx || qx[31]) ? 32'h7FFF_FFFF : qx;
    end
    if (sgny_r[SGN_END]) begin
      sat_y = (ovy || qy > 32'h8000_0000) ? 32'h8000_0000 : 32'(-qy);
    end else begin
      sat_y = (ovy || qy[31]) ? 32'h7FFF_FFFF : qy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xo_r[0] <= sat_x;
      yo_r[0] <= sat_y;
      for (int i = 1; i <= XY_DLY; i++) begin
        xo_r[i] <= xo_r[i-1];
        yo_r[i] <= yo_r[i-1];
      end
    end
  end

  // Ray cosine: square root, then division of the scaled focal length.
  logic [31:0]     root;
  logic [C_NW-1:0] nc_r;
  logic [C_DW-1:0] dc_r;
  logic [C_QW-1:0] qc;
  logic            ovc;
  logic [16:0]     cos_r;

  dpu_sqrt_pipe u_sqrt (
    .clk(clk), .en(adv), .val({2'b0, s_r, 28'b0}), .root(root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      nc_r <= {1'b0, fm_nz, 30'b0} + C_NW'(root[31:1]);
      dc_r <= root;
    end
  end

  dpu_div_pipe #(.NUM_W(C_NW), .DEN_W(C_DW), .QUO_W(C_QW)) u_div_c (
    .clk(clk), .en(adv), .num(nc_r), .den(dc_r), .quo(qc), .ovf(ovc)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_r <= (ovc || qc > COS_ONE) ? COS_ONE : qc;
    end
  end

  assign out_valid           = vld_r[LAT];
  assign out_data.point_x    = xo_r[XY_DLY];
  assign out_data.point_y    = yo_r[XY_DLY];
  assign out_data.point_z    = depth_r[LAT];
  assign out_data.ray_cosine = cos_r;

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ray_cosine <= COS_ONE)
    else $error("ray cosine above one");

  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> vld_r == '0)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule
